FILE: hw/rtl/bsam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsam_pkg;

    // Transaction operations carried in s_tuser
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    // Match kinds carried in m_tuser
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WEEKLY = 2'd1;
    localparam logic [1:0] KIND_EVENT  = 2'd2;

    // Store layout
    localparam int WEEK_SLOT_BYTES = 7;
    localparam int EVENT_BYTES     = 10;
    localparam int DAYS_PER_WEEK   = 7;

    // Byte offsets inside a weekly slot
    localparam logic [3:0] WK_HOUR_OFS   = 4'd1;
    localparam logic [3:0] WK_MINUTE_OFS = 4'd2;
    localparam logic [3:0] WK_ENABLE_OFS = 4'd3;

    // Byte offsets inside an event slot
    localparam logic [3:0] EV_DAY_OFS     = 4'd0;
    localparam logic [3:0] EV_MONTH_OFS   = 4'd1;
    localparam logic [3:0] EV_CENTURY_OFS = 4'd2;
    localparam logic [3:0] EV_YEAR_OFS    = 4'd3;
    localparam logic [3:0] EV_HOUR_OFS    = 4'd4;
    localparam logic [3:0] EV_MINUTE_OFS  = 4'd5;
    localparam logic [3:0] EV_ENABLE_OFS  = 4'd6;

    // Relay enable bytes per slot, then the duration byte
    localparam logic [1:0] NUM_RELAYS = 2'd3;

    // Year split: century = (year * YEAR_RECIP) >> YEAR_SHIFT, exact for 14-bit years
    localparam int YEAR_BASE  = 100;
    localparam int YEAR_RECIP = 5243;
    localparam int YEAR_SHIFT = 19;

    // Store access command from the sequencer to the RAM
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    // Map weekday 1 (Sunday) .. 7 (Saturday) to its day block, Monday first
    function automatic logic [2:0] day_index(input logic [2:0] wday);
        logic [2:0] idx;
        unique case (wday)
            3'd1:    idx = 3'd6;
            3'd2:    idx = 3'd0;
            3'd3:    idx = 3'd1;
            3'd4:    idx = 3'd2;
            3'd5:    idx = 3'd3;
            3'd6:    idx = 3'd4;
            3'd7:    idx = 3'd5;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bsam_store_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bsam_store_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                  aclk,
    input  bsam_pkg::mem_cmd_t   cmd,
    input  wire  [AW-1:0]        addr,
    input  wire  [7:0]           wdata,
    output logic [7:0]           rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    // Single port: write or registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            store_mem[addr] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bsam_scan_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsam_scan_ctrl #(
    parameter int STORE_DEPTH   = 1024,
    parameter int SLOTS_PER_DAY = 4,
    parameter int AW            = 10
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [55:0]          s_tdata,
    input  wire  [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [39:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output bsam_pkg::mem_cmd_t   mem_cmd,
    output logic [AW-1:0]        mem_addr,
    output logic [7:0]           mem_wdata,
    input  wire  [7:0]           mem_rdata
);

    localparam int DAY_BYTES  = bsam_pkg::WEEK_SLOT_BYTES * SLOTS_PER_DAY;
    localparam int COUNT_ADDR = bsam_pkg::DAYS_PER_WEEK * DAY_BYTES;
    localparam int IW         = $clog2(STORE_DEPTH + 512);
    localparam int SW         = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_READ_USE,
        S_CHK,
        S_WK_RD,
        S_WK_USE,
        S_FIRE_RD,
        S_FIRE_USE,
        S_DEL_DAY,
        S_DEL_CNT,
        S_CNT_RD,
        S_CNT_USE,
        S_EV_LOOP,
        S_EV_SKIP,
        S_EV_SKIP_USE,
        S_EV_RD,
        S_EV_USE,
        S_OUT
    } state_t;

    state_t         state_reg;

    // Captured transaction fields
    logic [7:0]     wdata_reg;
    logic [2:0]     wday_reg;
    logic [4:0]     hour_reg;
    logic [5:0]     minute_reg;
    logic [4:0]     mday_reg;
    logic [3:0]     month_reg;
    logic [13:0]    year_reg;
    logic [7:0]     century_reg;
    logic [6:0]     year_lo_reg;

    // Scan state
    logic [IW-1:0]  ptr_reg;
    logic [3:0]     fidx_reg;
    logic [SW-1:0]  slot_reg;
    logic [1:0]     relay_reg;
    logic [7:0]     count_reg;
    logic [7:0]     n_reg;
    logic           rd_ok_reg;

    // Result under construction
    logic [1:0]     kind_reg;
    logic [2:0]     mask_reg;
    logic [7:0]     dur_reg;
    logic           werr_reg;
    logic [7:0]     evl_reg;
    logic [7:0]     rdata_reg;

    // Output register
    logic           m_valid_reg;
    logic [39:0]    m_data_reg;
    logic [1:0]     m_user_reg;

    logic [IW-1:0]  addr_int;
    logic           in_range;
    logic [7:0]     byte_in;
    logic [7:0]     ev_expect;
    logic [7:0]     wk_expect;
    logic [26:0]    year_prod;
    logic [14:0]    cent_x100;
    logic [IW-1:0]  day_base;
    logic           ev_past_end;

    // Century of the incoming year by reciprocal multiply
    assign year_prod = {13'd0, s_tdata[54:41]} * 27'(bsam_pkg::YEAR_RECIP);
    assign cent_x100 = {7'd0, century_reg} * 15'(bsam_pkg::YEAR_BASE);
    assign day_base  = IW'(bsam_pkg::day_index(wday_reg)) * IW'(DAY_BYTES);
    assign ev_past_end = (ptr_reg + IW'(bsam_pkg::EVENT_BYTES - 1)) >= IW'(STORE_DEPTH);

    // Store address and command
    always_comb begin
        if (state_reg == S_CNT_RD || state_reg == S_DEL_CNT) begin
            addr_int = IW'(COUNT_ADDR);
        end else begin
            addr_int = ptr_reg + IW'(fidx_reg);
        end
    end

    assign in_range = addr_int < IW'(STORE_DEPTH);
    assign mem_addr = addr_int[AW-1:0];

    always_comb begin
        mem_cmd.rd = 1'b0;
        mem_cmd.wr = 1'b0;
        mem_wdata  = 8'd0;
        unique case (state_reg)
            S_READ, S_WK_RD, S_FIRE_RD, S_CNT_RD, S_EV_SKIP, S_EV_RD: begin
                mem_cmd.rd = in_range;
            end
            S_WRITE: begin
                mem_cmd.wr = in_range;
                mem_wdata  = wdata_reg;
            end
            S_DEL_DAY: begin
                mem_cmd.wr = in_range;
            end
            S_DEL_CNT: begin
                mem_cmd.wr = in_range;
                mem_wdata  = count_reg - 8'd1;
            end
            default: begin
            end
        endcase
    end

    // Bytes beyond the store read as zero
    assign byte_in = rd_ok_reg ? mem_rdata : 8'd0;

    // Expected byte for the field under test
    always_comb begin
        case (fidx_reg)
            bsam_pkg::EV_DAY_OFS:     ev_expect = {3'd0, mday_reg};
            bsam_pkg::EV_MONTH_OFS:   ev_expect = {4'd0, month_reg};
            bsam_pkg::EV_CENTURY_OFS: ev_expect = century_reg;
            bsam_pkg::EV_YEAR_OFS:    ev_expect = {1'b0, year_lo_reg};
            bsam_pkg::EV_HOUR_OFS:    ev_expect = {3'd0, hour_reg};
            default:                  ev_expect = {2'd0, minute_reg};
        endcase
    end

    assign wk_expect = (fidx_reg == bsam_pkg::WK_HOUR_OFS) ? {3'd0, hour_reg}
                                                           : {2'd0, minute_reg};

    assign s_tready = (state_reg == S_IDLE);

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        rd_ok_reg <= in_range;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop a taken result unless a new one loads in this cycle
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        ptr_reg     <= IW'(s_tdata[9:0]);
                        wdata_reg   <= s_tdata[17:10];
                        wday_reg    <= s_tdata[20:18];
                        hour_reg    <= s_tdata[25:21];
                        minute_reg  <= s_tdata[31:26];
                        mday_reg    <= s_tdata[36:32];
                        month_reg   <= s_tdata[40:37];
                        year_reg    <= s_tdata[54:41];
                        century_reg <= year_prod[bsam_pkg::YEAR_SHIFT +: 8];
                        fidx_reg    <= 4'd0;
                        kind_reg    <= bsam_pkg::KIND_NONE;
                        mask_reg    <= 3'd0;
                        dur_reg     <= 8'd0;
                        werr_reg    <= 1'b0;
                        evl_reg     <= 8'd0;
                        rdata_reg   <= 8'd0;
                        case (s_tuser)
                            bsam_pkg::OP_WRITE: state_reg <= S_WRITE;
                            bsam_pkg::OP_READ:  state_reg <= S_READ;
                            bsam_pkg::OP_CHECK: state_reg <= S_CHK;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_WRITE: begin
                    state_reg <= S_IDLE;
                end
                S_READ: begin
                    state_reg <= S_READ_USE;
                end
                S_READ_USE: begin
                    rdata_reg <= byte_in;
                    state_reg <= S_OUT;
                end
                S_CHK: begin
                    year_lo_reg <= 7'(year_reg - cent_x100[13:0]);
                    if (wday_reg == 3'd0) begin
                        werr_reg  <= 1'b1;
                        state_reg <= S_CNT_RD;
                    end else begin
                        ptr_reg   <= day_base;
                        slot_reg  <= '0;
                        fidx_reg  <= bsam_pkg::WK_HOUR_OFS;
                        state_reg <= S_WK_RD;
                    end
                end
                S_WK_RD: begin
                    state_reg <= S_WK_USE;
                end
                S_WK_USE: begin
                    if (byte_in == wk_expect) begin
                        if (fidx_reg == bsam_pkg::WK_HOUR_OFS) begin
                            fidx_reg  <= bsam_pkg::WK_MINUTE_OFS;
                            state_reg <= S_WK_RD;
                        end else begin
                            kind_reg  <= bsam_pkg::KIND_WEEKLY;
                            fidx_reg  <= bsam_pkg::WK_ENABLE_OFS;
                            relay_reg <= 2'd0;
                            state_reg <= S_FIRE_RD;
                        end
                    end else if (slot_reg == SW'(SLOTS_PER_DAY - 1)) begin
                        state_reg <= S_CNT_RD;
                    end else begin
                        slot_reg  <= slot_reg + SW'(1);
                        ptr_reg   <= ptr_reg + IW'(bsam_pkg::WEEK_SLOT_BYTES);
                        fidx_reg  <= bsam_pkg::WK_HOUR_OFS;
                        state_reg <= S_WK_RD;
                    end
                end
                S_FIRE_RD: begin
                    state_reg <= S_FIRE_USE;
                end
                S_FIRE_USE: begin
                    // Collect relay enables, then the duration byte
                    if (relay_reg != bsam_pkg::NUM_RELAYS) begin
                        mask_reg[relay_reg] <= (byte_in != 8'd0);
                        relay_reg <= relay_reg + 2'd1;
                        fidx_reg  <= fidx_reg + 4'd1;
                        state_reg <= S_FIRE_RD;
                    end else begin
                        dur_reg <= byte_in;
                        if (kind_reg == bsam_pkg::KIND_WEEKLY) begin
                            state_reg <= S_CNT_RD;
                        end else begin
                            fidx_reg  <= bsam_pkg::EV_DAY_OFS;
                            state_reg <= S_DEL_DAY;
                        end
                    end
                end
                S_DEL_DAY: begin
                    state_reg <= S_DEL_CNT;
                end
                S_DEL_CNT: begin
                    evl_reg   <= count_reg - 8'd1;
                    state_reg <= S_OUT;
                end
                S_CNT_RD: begin
                    state_reg <= S_CNT_USE;
                end
                S_CNT_USE: begin
                    if (kind_reg == bsam_pkg::KIND_WEEKLY) begin
                        evl_reg   <= byte_in;
                        state_reg <= S_OUT;
                    end else begin
                        count_reg <= byte_in;
                        n_reg     <= 8'd0;
                        ptr_reg   <= IW'(COUNT_ADDR + 1);
                        fidx_reg  <= bsam_pkg::EV_DAY_OFS;
                        state_reg <= S_EV_LOOP;
                    end
                end
                S_EV_LOOP: begin
                    if (n_reg == count_reg) begin
                        evl_reg   <= count_reg;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_EV_SKIP;
                    end
                end
                S_EV_SKIP: begin
                    // Stop when the next slot would run past the store
                    if (ev_past_end) begin
                        evl_reg   <= count_reg;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_EV_SKIP_USE;
                    end
                end
                S_EV_SKIP_USE: begin
                    if (byte_in == 8'd0) begin
                        ptr_reg   <= ptr_reg + IW'(bsam_pkg::EVENT_BYTES);
                        state_reg <= S_EV_SKIP;
                    end else begin
                        state_reg <= S_EV_RD;
                    end
                end
                S_EV_RD: begin
                    state_reg <= S_EV_USE;
                end
                S_EV_USE: begin
                    if (byte_in == ev_expect) begin
                        if (fidx_reg == bsam_pkg::EV_MINUTE_OFS) begin
                            kind_reg  <= bsam_pkg::KIND_EVENT;
                            fidx_reg  <= bsam_pkg::EV_ENABLE_OFS;
                            relay_reg <= 2'd0;
                            state_reg <= S_FIRE_RD;
                        end else begin
                            fidx_reg  <= fidx_reg + 4'd1;
                            state_reg <= S_EV_RD;
                        end
                    end else begin
                        ptr_reg   <= ptr_reg + IW'(bsam_pkg::EVENT_BYTES);
                        n_reg     <= n_reg + 8'd1;
                        fidx_reg  <= bsam_pkg::EV_DAY_OFS;
                        state_reg <= S_EV_LOOP;
                    end
                end
                S_OUT: begin
                    // Load the output register once it is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= kind_reg;
                        m_data_reg  <= {5'd0, evl_reg, werr_reg,
                                        (mask_reg != 3'd0) ? minute_reg : 6'd0,
                                        (mask_reg != 3'd0) ? dur_reg : 8'd0,
                                        (mask_reg != 3'd0), mask_reg, rdata_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bell_schedule_alarm_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports         Contents
// -------  ------------  ---------------------------------------------------------
// input    s_t*          tuser: operation; tdata: address, write_data, weekday,
//                        hour, minute, day_of_month, month, year
// result   m_t*          tuser: match_kind; tdata: read_data, relay_mask,
//                        common_relay_on, on_duration, start_minute,
//                        weekday_error, events_left
//
// One transaction is worked at a time; every store byte examined is issued on the
// single RAM port and then compared against the registered read data.
// Reset clears only control state; the store contents are undefined until written.
// A finished result waits in the output register while the next transaction is
// accepted; a stalled result stalls only the next transaction that has a result.

module bell_schedule_alarm_matcher #(
    parameter int STORE_DEPTH   = 1024,
    parameter int SLOTS_PER_DAY = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [9:0] address, [17:10] write_data, [20:18] weekday, [25:21] hour,
    // [31:26] minute, [36:32] day_of_month, [40:37] month, [54:41] year, [55] zero
    input  wire  [55:0] s_tdata,
    // [1:0] operation
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] read_data, [10:8] relay_mask, [11] common_relay_on, [19:12] on_duration,
    // [25:20] start_minute, [26] weekday_error, [34:27] events_left, [39:35] zero
    output logic [39:0] m_tdata,
    // [1:0] match_kind
    output logic [1:0]  m_tuser
);

    localparam int AW = $clog2(STORE_DEPTH);

    bsam_pkg::mem_cmd_t mem_cmd;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;

    bsam_scan_ctrl #(
        .STORE_DEPTH   (STORE_DEPTH),
        .SLOTS_PER_DAY (SLOTS_PER_DAY),
        .AW            (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bsam_store_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
